/* rtl/core/pcr_pkg.sv */
// Shared types, widths and codes for the polygon centroid and recentring block.
`timescale 1ns / 1ps
package pcr_pkg;

  // Vertex store depth and the counters that follow from it
  localparam int MAX_VERT = 8;
  localparam int CNT_W    = $clog2(MAX_VERT + 2);
  localparam int IDX_W    = $clog2(MAX_VERT);

  // Arithmetic widths
  localparam int W_CRD  = 16;
  localparam int W_SUM  = 56;
  localparam int W_DEN  = 42;
  localparam int STEP_W = $clog2(W_SUM);

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_AREA = 2'd1;
  localparam logic [1:0] ST_TOO_MANY  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_CX   = 2'd1;
  localparam logic [1:0] CFG_CY   = 2'd2;

  typedef logic signed [W_CRD-1:0] coord_t;

  typedef struct packed {
    coord_t y;
    coord_t x;
  } vertex_t;

endpackage

/* rtl/core/pcr_store.sv */
// Vertex store: one write port, one registered read port.
`timescale 1ns / 1ps
module pcr_store (
  input  logic                      clk,
  input  logic                      we,
  input  logic [pcr_pkg::IDX_W-1:0] waddr,
  input  pcr_pkg::vertex_t          wdata,
  input  logic                      re,
  input  logic [pcr_pkg::IDX_W-1:0] raddr,
  output pcr_pkg::vertex_t          rdata
);
  import pcr_pkg::*;

  vertex_t mem [MAX_VERT];
  vertex_t rdata_r;

  // Write the arriving vertex
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/pcr_div.sv */
// Restoring divider, one quotient bit per cycle, signed result saturated to 16 bits.
`timescale 1ns / 1ps
module pcr_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [pcr_pkg::W_SUM-1:0] dividend,
  input  logic signed [pcr_pkg::W_DEN-1:0] divisor,
  output logic                           done,
  output pcr_pkg::coord_t                quot
);
  import pcr_pkg::*;

  logic                busy_r, busy_nxt;
  logic                fin_r, fin_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                neg_r, neg_nxt;
  logic [W_SUM-1:0]    quo_r, quo_nxt;
  logic [W_DEN-1:0]    rem_r, rem_nxt;
  logic [W_DEN-1:0]    dmag_r, dmag_nxt;
  logic [W_DEN:0]      trial;
  logic [W_DEN:0]      diff;
  logic                ge;

  // One restoring step: shift in the next dividend bit, try the subtract
  assign trial = {rem_r, quo_r[W_SUM-1]};
  assign diff  = trial - {1'b0, dmag_r};
  assign ge    = ~diff[W_DEN];

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    step_nxt = step_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dmag_nxt = dmag_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      neg_nxt  = dividend[W_SUM-1] ^ divisor[W_DEN-1];
      quo_nxt  = dividend[W_SUM-1] ? W_SUM'(-dividend) : W_SUM'(dividend);
      rem_nxt  = '0;
      dmag_nxt = divisor[W_DEN-1] ? W_DEN'(-divisor) : W_DEN'(divisor);
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[W_DEN-1:0] : trial[W_DEN-1:0];
      quo_nxt  = {quo_r[W_SUM-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(W_SUM - 1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    neg_r  <= neg_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dmag_r <= dmag_nxt;
  end

  // Apply sign and clamp the magnitude to the 16-bit range
  always_comb begin
    if (neg_r) begin
      if (quo_r > W_SUM'(32768)) begin
        quot = 16'sh8000;
      end else begin
        quot = coord_t'(-quo_r[W_CRD:0]);
      end
    end else begin
      if (quo_r > W_SUM'(32767)) begin
        quot = 16'sh7fff;
      end else begin
        quot = coord_t'(quo_r[W_CRD-1:0]);
      end
    end
  end

  assign done = fin_r;

endmodule

/* rtl/core/polygon_centroid_recenter.sv */
// Polygon centroid and recentring: top level with sequencer and shared multiplier.
// A first vertex that is not the last is only stored; later ones up to MAX_VERT are stored and run
// through edge steps S_E1 to S_E6. Final vertex, unless too many: closing edge in the same steps,
// area check and, if nonzero, two divisions in turn on the shared divider. In mode 1 a store
// read precedes each result. Results leave while the sink has room; no input is taken meanwhile.
// Synchronous active-low reset clears the sequencer, counters, accumulators and control registers.
`timescale 1ns / 1ps
module polygon_centroid_recenter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] vertex_x, [31:16] vertex_y
  input  logic        in_tlast,   // last_vertex
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [15:0] point_x, [31:16] point_y,
                                  // [47:32] centroid_x, [63:48] centroid_y
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast,  // last_result
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import pcr_pkg::*;

  localparam int W_MA   = W_CRD + 1;
  localparam int W_CR   = 2 * W_CRD + 1;
  localparam int W_PROD = W_MA + W_CR;
  localparam int W_AREA = 40;
  localparam int W_RC   = W_CRD + 2;

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_E1    = 4'd1;
  localparam logic [3:0] S_E2    = 4'd2;
  localparam logic [3:0] S_E3    = 4'd3;
  localparam logic [3:0] S_E4    = 4'd4;
  localparam logic [3:0] S_E5    = 4'd5;
  localparam logic [3:0] S_E6    = 4'd6;
  localparam logic [3:0] S_CHECK = 4'd7;
  localparam logic [3:0] S_DIVX  = 4'd8;
  localparam logic [3:0] S_DIVY  = 4'd9;
  localparam logic [3:0] S_RD    = 4'd10;
  localparam logic [3:0] S_LOAD  = 4'd11;

  function automatic coord_t sat16(input logic signed [W_RC-1:0] v);
    if (v > W_RC'(32767)) begin
      return 16'sh7fff;
    end else if (v < -W_RC'(32768)) begin
      return 16'sh8000;
    end else begin
      return coord_t'(v);
    end
  endfunction

  logic [3:0]               state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]         k_r, k_nxt;
  logic                     last_r, last_nxt;
  logic                     close_r, close_nxt;
  logic                     mode_r, mode_nxt;
  logic [1:0]               status_r, status_nxt;
  vertex_t                  first_r, first_nxt;
  vertex_t                  prev_r, prev_nxt;
  vertex_t                  ea_r, ea_nxt;
  vertex_t                  eb_r, eb_nxt;
  logic signed [W_CR-1:0]   t_r, t_nxt;
  logic signed [W_CR-1:0]   cr_r, cr_nxt;
  logic signed [W_PROD-1:0] prod_r;
  logic signed [W_AREA-1:0] area_r, area_nxt;
  logic signed [W_SUM-1:0]  wx_r, wx_nxt;
  logic signed [W_SUM-1:0]  wy_r, wy_nxt;
  coord_t                   cx_r, cx_nxt;
  coord_t                   cy_r, cy_nxt;
  logic                     cfg_mode_r;
  coord_t                   cfg_cx_r;
  coord_t                   cfg_cy_r;

  logic                     ovalid_r, ovalid_nxt;
  logic [63:0]              odata_r, odata_nxt;
  logic [1:0]               ouser_r, ouser_nxt;
  logic                     olast_r, olast_nxt;

  logic signed [W_MA-1:0]   mul_a;
  logic signed [W_CR-1:0]   mul_b;
  logic                     div_start;
  logic signed [W_SUM-1:0]  div_num;
  logic signed [W_DEN-1:0]  div_den;
  logic                     div_done;
  coord_t                   div_q;
  logic                     st_we;
  logic                     st_re;
  vertex_t                  st_rdata;
  vertex_t                  in_vtx;
  logic                     in_fire;
  logic                     out_free;
  logic [CNT_W-1:0]         n_emit;
  logic                     emit_last;
  coord_t                   px;
  coord_t                   py;

  assign in_vtx    = vertex_t'(in_tdata);
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !ovalid_r || out_tready;
  assign cfg_ready = 1'b1;

  // Configuration registers; index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r <= 1'b0;
      cfg_cx_r   <= '0;
      cfg_cy_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE: cfg_mode_r <= cfg_data[0];
        CFG_CX:   cfg_cx_r   <= coord_t'(cfg_data);
        CFG_CY:   cfg_cy_r   <= coord_t'(cfg_data);
        default:  ;
      endcase
    end
  end

  pcr_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (in_vtx),
    .re    (st_re),
    .raddr (k_r),
    .rdata (st_rdata)
  );

  // Divide weighted sums by three times the cross-product sum (six times the signed area)
  assign div_den = W_DEN'(area_r) + (W_DEN'(area_r) <<< 1);
  assign div_num = (state_r == S_CHECK) ? wx_r : wy_r;

  pcr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quot     (div_q)
  );

  // Shared multiplier operand select
  always_comb begin
    case (state_r)
      S_E1: begin
        mul_a = W_MA'(ea_r.x);
        mul_b = W_CR'(eb_r.y);
      end
      S_E2: begin
        mul_a = W_MA'(ea_r.y);
        mul_b = W_CR'(eb_r.x);
      end
      S_E4: begin
        mul_a = W_MA'(ea_r.x) + W_MA'(eb_r.x);
        mul_b = cr_r;
      end
      S_E5: begin
        mul_a = W_MA'(ea_r.y) + W_MA'(eb_r.y);
        mul_b = cr_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Recentred point from the stored vertex
  assign n_emit    = (count_r > CNT_W'(MAX_VERT)) ? CNT_W'(MAX_VERT) : count_r;
  assign emit_last = (CNT_W'(k_r) + 1'b1) == n_emit;
  assign px = sat16(W_RC'(st_rdata.x) - W_RC'(cx_r) + W_RC'(cfg_cx_r));
  assign py = sat16(W_RC'(st_rdata.y) - W_RC'(cy_r) + W_RC'(cfg_cy_r));

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    k_nxt      = k_r;
    last_nxt   = last_r;
    close_nxt  = close_r;
    mode_nxt   = mode_r;
    status_nxt = status_r;
    first_nxt  = first_r;
    prev_nxt   = prev_r;
    ea_nxt     = ea_r;
    eb_nxt     = eb_r;
    t_nxt      = t_r;
    cr_nxt     = cr_r;
    area_nxt   = area_r;
    wx_nxt     = wx_r;
    wy_nxt     = wy_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    ouser_nxt  = ouser_r;
    olast_nxt  = olast_r;
    st_we      = 1'b0;
    st_re      = 1'b0;
    div_start  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          last_nxt = in_tlast;
          if (in_tlast) begin
            mode_nxt = cfg_mode_r;
          end
          if (count_r < CNT_W'(MAX_VERT)) begin
            st_we     = 1'b1;
            count_nxt = count_r + 1'b1;
            prev_nxt  = in_vtx;
            if (count_r == '0) begin
              first_nxt = in_vtx;
              if (in_tlast) begin
                // Single vertex: close on itself
                ea_nxt    = in_vtx;
                eb_nxt    = in_vtx;
                close_nxt = 1'b1;
                state_nxt = S_E1;
              end
            end else begin
              ea_nxt    = prev_r;
              eb_nxt    = in_vtx;
              close_nxt = 1'b0;
              state_nxt = S_E1;
            end
          end else begin
            count_nxt = CNT_W'(MAX_VERT + 1);
            if (in_tlast) begin
              status_nxt = ST_TOO_MANY;
              cx_nxt     = '0;
              cy_nxt     = '0;
              k_nxt      = '0;
              state_nxt  = cfg_mode_r ? S_RD : S_LOAD;
            end
          end
        end
      end
      S_E1: state_nxt = S_E2;
      S_E2: begin
        t_nxt     = prod_r[W_CR-1:0];
        state_nxt = S_E3;
      end
      S_E3: begin
        cr_nxt    = t_r - $signed(prod_r[W_CR-1:0]);
        state_nxt = S_E4;
      end
      S_E4: begin
        area_nxt  = area_r + W_AREA'(cr_r);
        state_nxt = S_E5;
      end
      S_E5: begin
        wx_nxt    = wx_r + W_SUM'(prod_r);
        state_nxt = S_E6;
      end
      S_E6: begin
        wy_nxt = wy_r + W_SUM'(prod_r);
        if (close_r) begin
          state_nxt = S_CHECK;
        end else if (last_r) begin
          // Closing edge back to the first vertex
          ea_nxt    = prev_r;
          eb_nxt    = first_r;
          close_nxt = 1'b1;
          state_nxt = S_E1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CHECK: begin
        k_nxt = '0;
        if (area_r == '0) begin
          status_nxt = ST_ZERO_AREA;
          cx_nxt     = '0;
          cy_nxt     = '0;
          state_nxt  = mode_r ? S_RD : S_LOAD;
        end else begin
          status_nxt = ST_OK;
          div_start  = 1'b1;
          state_nxt  = S_DIVX;
        end
      end
      S_DIVX: begin
        if (div_done) begin
          cx_nxt    = div_q;
          div_start = 1'b1;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          cy_nxt    = div_q;
          state_nxt = mode_r ? S_RD : S_LOAD;
        end
      end
      S_RD: begin
        st_re     = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ouser_nxt  = status_r;
          if (mode_r) begin
            odata_nxt = {cy_r, cx_r, py, px};
            olast_nxt = emit_last;
          end else begin
            odata_nxt = {cy_r, cx_r, 32'd0};
            olast_nxt = 1'b1;
          end
          if (!mode_r || emit_last) begin
            // Polygon done: clear for the next one
            count_nxt = '0;
            area_nxt  = '0;
            wx_nxt    = '0;
            wy_nxt    = '0;
            first_nxt = '0;
            prev_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and accumulator registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      k_r      <= '0;
      last_r   <= 1'b0;
      close_r  <= 1'b0;
      mode_r   <= 1'b0;
      status_r <= ST_OK;
      first_r  <= '0;
      prev_r   <= '0;
      area_r   <= '0;
      wx_r     <= '0;
      wy_r     <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      k_r      <= k_nxt;
      last_r   <= last_nxt;
      close_r  <= close_nxt;
      mode_r   <= mode_nxt;
      status_r <= status_nxt;
      first_r  <= first_nxt;
      prev_r   <= prev_nxt;
      area_r   <= area_nxt;
      wx_r     <= wx_nxt;
      wy_r     <= wy_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ea_r    <= ea_nxt;
    eb_r    <= eb_nxt;
    t_r     <= t_nxt;
    cr_r    <= cr_nxt;
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the polygon centroid and recentring block.
`timescale 1ns / 1ps
module tb;
  import pcr_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int LONG_HOLD   = 500;
  localparam int RANDOM_ITEMS_PER_PHASE = 54;
  localparam int RANDOM_PHASES = 6;

  localparam logic       MODE_CENTROID = 1'b0;
  localparam logic       MODE_RECENTER = 1'b1;
  localparam logic [1:0] CFG_SPARE     = 2'd3;   // unmapped index, must be ignored

  typedef enum int {SHAPE_LOCAL, SHAPE_FULL, SHAPE_EXTREME, SHAPE_LINE, SHAPE_POINT} shape_t;

  typedef struct {
    vertex_t v;
    logic    last;
  } vertex_item_t;

  typedef struct packed {
    coord_t     px;
    coord_t     py;
    coord_t     cx;
    coord_t     cy;
    logic [1:0] status;
    logic       last;
  } point_result_t;

  // DUT connections; the inputs are at known values from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  polygon_centroid_recenter dut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the block state
  vertex_t stored_vertices [MAX_VERT];
  int      polygon_count = 0;
  vertex_t first_corner = '0;
  vertex_t prev_corner = '0;
  longint  area_acc = 0;
  longint  moment_x_acc = 0;
  longint  moment_y_acc = 0;
  logic    mode_reg = MODE_CENTROID;
  coord_t  offset_x = '0;
  coord_t  offset_y = '0;

  vertex_item_t  pending_vertices[$];
  point_result_t expected_points[$];

  int   queued_count = 0;
  int   accepted_count = 0;
  int   fault_count = 0;
  int   cycle_count = 0;
  logic in_taken = 1'b0;
  int   tx_gap = 0;
  int   rx_gap = 0;
  bit   tx_idle_en = 1'b1;
  bit   rx_idle_en = 1'b1;
  int   hold_requests = 0;
  int   hold_served = 0;
  int   hold_left = 0;

  function automatic int rand_between(input int lo, input int hi);
    return int'($urandom_range(0, hi - lo)) + lo;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = rand_between(0, 99);
    if (r < 60) return 0;
    if (r < 92) return rand_between(1, 3);
    return rand_between(15, 60);
  endfunction

  function automatic coord_t clip16(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return coord_t'(v);
  endfunction

  // Add one edge to the shoelace sums
  function automatic void add_edge_moment(input vertex_t a, input vertex_t b);
    longint x1, y1, x2, y2, cr_val;
    x1 = a.x;
    y1 = a.y;
    x2 = b.x;
    y2 = b.y;
    cr_val = x1 * y2 - y1 * x2;
    area_acc += cr_val;
    moment_x_acc += (x1 + x2) * cr_val;
    moment_y_acc += (y1 + y2) * cr_val;
  endfunction

  // Fold one vertex into the shadow state; on the final one queue its results
  function automatic void predict_vertex(input vertex_t v, input logic last);
    longint        cx, cy;
    logic [1:0]    status;
    int            n;
    point_result_t r;
    cx = 0;
    cy = 0;
    status = ST_OK;
    if (polygon_count < MAX_VERT) begin
      stored_vertices[polygon_count] = v;
      if (polygon_count == 0) first_corner = v;
      else add_edge_moment(prev_corner, v);
      prev_corner = v;
      polygon_count++;
    end else begin
      polygon_count = MAX_VERT + 1;
    end
    if (!last) return;

    if (polygon_count > MAX_VERT) begin
      status = ST_TOO_MANY;
    end else begin
      add_edge_moment(prev_corner, first_corner);
      if (area_acc == 0) begin
        status = ST_ZERO_AREA;
      end else begin
        cx = clip16(moment_x_acc / (3 * area_acc));
        cy = clip16(moment_y_acc / (3 * area_acc));
      end
    end

    if (mode_reg == MODE_CENTROID) begin
      r.px = '0;
      r.py = '0;
      r.cx = coord_t'(cx);
      r.cy = coord_t'(cy);
      r.status = status;
      r.last = 1'b1;
      expected_points.push_back(r);
    end else begin
      n = (polygon_count > MAX_VERT) ? MAX_VERT : polygon_count;
      for (int k = 0; k < n; k++) begin
        r.px = clip16(longint'(stored_vertices[k].x) - cx + longint'(offset_x));
        r.py = clip16(longint'(stored_vertices[k].y) - cy + longint'(offset_y));
        r.cx = coord_t'(cx);
        r.cy = coord_t'(cy);
        r.status = status;
        r.last = (k + 1 == n);
        expected_points.push_back(r);
      end
    end

    polygon_count = 0;
    first_corner = '0;
    prev_corner = '0;
    area_acc = 0;
    moment_x_acc = 0;
    moment_y_acc = 0;
  endfunction

  task automatic queue_vertex(input int x, input int y, input logic last);
    vertex_item_t it;
    it.v.x = coord_t'(x);
    it.v.y = coord_t'(y);
    it.last = last;
    pending_vertices.push_back(it);
    queued_count++;
  endtask

  function automatic int extreme_coord();
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  // Queue one polygon of nv vertices with the given shape
  task automatic queue_polygon(input int nv, input shape_t shape);
    int bx, by, dx, dy, x, y;
    bx = rand_between(-20000, 20000);
    by = rand_between(-20000, 20000);
    dx = rand_between(-100, 100);
    dy = rand_between(-100, 100);
    if (shape == SHAPE_LINE) begin
      bx = rand_between(-1000, 1000);
      by = rand_between(-1000, 1000);
    end
    for (int k = 0; k < nv; k++) begin
      case (shape)
        SHAPE_LOCAL: begin
          x = bx + rand_between(-300, 300);
          y = by + rand_between(-300, 300);
        end
        SHAPE_FULL: begin
          x = int'(coord_t'($urandom));
          y = int'(coord_t'($urandom));
        end
        SHAPE_EXTREME: begin
          x = extreme_coord();
          y = extreme_coord();
        end
        SHAPE_LINE: begin
          x = bx + k * dx;
          y = by + k * dy;
        end
        default: begin
          x = bx;
          y = by;
        end
      endcase
      queue_vertex(x, y, k == nv - 1);
    end
  endtask

  // Register write; the shadow copy follows at the handshake
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MODE: mode_reg = val[0];
      CFG_CX:   offset_x = coord_t'(val);
      CFG_CY:   offset_y = coord_t'(val);
      default:  ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every queued vertex is taken and every result has arrived
  task automatic wait_drained(input int tail);
    while (accepted_count != queued_count || expected_points.size() != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  // Vertex driver: change inputs on the falling edge
  always @(negedge clk) begin
    if (!rst_n || (in_tvalid && !in_taken)) begin
      // hold the current item
    end else if (tx_gap > 0) begin
      in_tvalid <= 1'b0;
      tx_gap <= tx_gap - 1;
    end else if (pending_vertices.size() > 0) begin
      in_tvalid <= 1'b1;
      in_tdata  <= pending_vertices[0].v;
      in_tlast  <= pending_vertices[0].last;
      void'(pending_vertices.pop_front());
      tx_gap <= tx_idle_en ? pick_gap() : 0;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Predict at each accepted vertex
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_vertex(vertex_t'(in_tdata), in_tlast);
      accepted_count <= accepted_count + 1;
    end
    in_taken <= rst_n && in_tvalid && in_tready;
  end

  // Result sink: random stalls plus the occasional long hold-off
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (rx_idle_en && $urandom_range(0, 3) == 0) rx_gap <= pick_gap();
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin : result_check
    point_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.px = out_tdata[15:0];
      got.py = out_tdata[31:16];
      got.cx = out_tdata[47:32];
      got.cy = out_tdata[63:48];
      got.status = out_tuser;
      got.last = out_tlast;
      if (expected_points.size() == 0) begin
        if (fault_count < 10)
          $display("%0t: unexpected result px=%0d py=%0d cx=%0d cy=%0d st=%0d last=%0b",
                   $realtime, got.px, got.py, got.cx, got.cy, got.status, got.last);
        fault_count++;
      end else begin
        want = expected_points.pop_front();
        if (got.px !== want.px || got.py !== want.py || got.cx !== want.cx ||
            got.cy !== want.cy || got.status !== want.status || got.last !== want.last) begin
          if (fault_count < 10)
            $display({"%0t: mismatch exp px=%0d py=%0d cx=%0d cy=%0d st=%0d last=%0b",
                      " / got px=%0d py=%0d cx=%0d cy=%0d st=%0d last=%0b"},
                     $realtime, want.px, want.py, want.cx, want.cy, want.status, want.last,
                     got.px, got.py, got.cx, got.cy, got.status, got.last);
          fault_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int target;
    int nv;
    int r;
    shape_t shape;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // Directed, centroid mode: triangle, lone vertex, collinear run,
    // overflowing polygon and a triangle on the coordinate extremes
    queue_vertex(0, 0, 1'b0);
    queue_vertex(160, 0, 1'b0);
    queue_vertex(0, 160, 1'b1);
    queue_vertex(32767, -32768, 1'b1);
    queue_vertex(16, 16, 1'b0);
    queue_vertex(32, 32, 1'b0);
    queue_vertex(48, 48, 1'b1);
    queue_polygon(MAX_VERT + 1, SHAPE_LOCAL);
    queue_vertex(-32768, -32768, 1'b0);
    queue_vertex(32767, -32768, 1'b0);
    queue_vertex(32767, 32767, 1'b1);
    wait_drained(16);

    // Directed, recentring mode with saturating offsets
    write_reg(CFG_MODE, 16'(MODE_RECENTER));
    write_reg(CFG_CX, 16'h7fff);
    write_reg(CFG_CY, 16'h8000);
    write_reg(CFG_SPARE, 16'hffff);
    @(posedge clk);
    queue_vertex(32767, 32767, 1'b0);
    queue_vertex(-32768, 32767, 1'b0);
    queue_vertex(-32768, -32768, 1'b0);
    queue_vertex(32767, -32768, 1'b1);
    queue_vertex(5, -7, 1'b0);
    queue_vertex(-3, 9, 1'b1);
    wait_drained(16);

    // Random phases, each with its own register setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_MODE, 16'(MODE_CENTROID));
          write_reg(CFG_CX, 16'($urandom));
          write_reg(CFG_CY, 16'($urandom));
        end
        1: begin
          write_reg(CFG_MODE, 16'(MODE_RECENTER));
          write_reg(CFG_CX, 16'h7fff);
          write_reg(CFG_CY, 16'h7fff);
        end
        2: begin
          write_reg(CFG_MODE, 16'(MODE_RECENTER));
          write_reg(CFG_CX, 16'h8000);
          write_reg(CFG_CY, 16'h8000);
        end
        3: begin
          write_reg(CFG_MODE, 16'(MODE_RECENTER));
          write_reg(CFG_CX, 16'($urandom));
          write_reg(CFG_CY, 16'($urandom));
        end
        4: begin
          write_reg(CFG_MODE, 16'(MODE_CENTROID));
          write_reg(CFG_CX, 16'h0000);
          write_reg(CFG_CY, 16'($urandom));
        end
        default: begin
          write_reg(CFG_MODE, 16'(MODE_RECENTER));
          write_reg(CFG_CX, 16'h0000);
          write_reg(CFG_CY, 16'h0000);
        end
      endcase
      // Phase 3 runs with no idling on either side
      tx_idle_en = (ph != 3);
      rx_idle_en = (ph != 3);
      @(posedge clk);
      // Phase 2 opens with the sink held off so the block backs up
      if (ph == 2) hold_requests++;

      target = queued_count + RANDOM_ITEMS_PER_PHASE;
      while (queued_count < target) begin
        r = rand_between(0, 99);
        if (r < 10) nv = rand_between(1, 2);
        else if (r < 85) nv = rand_between(3, MAX_VERT);
        else nv = rand_between(MAX_VERT + 1, MAX_VERT + 4);
        r = rand_between(0, 99);
        if (r < 50) shape = SHAPE_LOCAL;
        else if (r < 75) shape = SHAPE_FULL;
        else if (r < 85) shape = SHAPE_EXTREME;
        else if (r < 93) shape = SHAPE_LINE;
        else shape = SHAPE_POINT;
        queue_polygon(nv, shape);
      end
      wait_drained(16);
    end

    // Let any stray result show up before the verdict
    wait_drained(200);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
